// File: sv/wfsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsp_pkg: shared types and constants of the frame summary parser
// Holds the accepted byte record, the result record, the element-walk phase
// codes and the 802.11 field constants that the parser modules share.
// ----------------------------------------------------------------------------
package wfsp_pkg;

  // Fixed field widths.
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SSID_CNT_W = 6;
  localparam int unsigned SSID_WORDS = 4;
  localparam int unsigned SSID_SLOTS = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 384;

  // Element-walk phases.
  localparam logic [1:0] PH_SEEK = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Frame control codes and byte positions.
  localparam logic [1:0]         TYPE_MGMT       = 2'd0;
  localparam logic [3:0]         SUB_PROBE_REQ   = 4'd4;
  localparam logic [3:0]         SUB_PROBE_RESP  = 4'd5;
  localparam logic [3:0]         SUB_BEACON      = 4'd8;
  localparam logic [7:0]         EID_SSID        = 8'd0;
  localparam logic [COUNT_W-1:0] POS_SRC         = 16'd10;
  localparam logic [COUNT_W-1:0] POS_BSSID       = 16'd16;
  localparam logic [COUNT_W-1:0] IE_START_FIXED  = 16'd36;
  localparam logic [COUNT_W-1:0] IE_START_PREQ   = 16'd24;
  localparam logic [COUNT_W-1:0] MIN_FRAME_LEN   = 16'd24;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic signed [7:0] rssi;
    logic [7:0]        channel;
    logic              misc;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                       ftype;
    logic [3:0]                       subtype;
    logic signed [7:0]                rssi;
    logic [7:0]                       channel;
    logic [47:0]                      source_mac;
    logic [47:0]                      bssid_mac;
    logic [SSID_CNT_W-1:0]            ssid_len;
    logic [SSID_WORDS-1:0][63:0]      ssid_word;
  } summary_t;

endpackage
`default_nettype wire

// File: sv/wfsp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsp_in_reg: input register
// Captures one byte transfer with its side fields and holds it until the
// parser consumes it.
// ----------------------------------------------------------------------------
module wfsp_in_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  output logic                 ready_o,
  input  wire wfsp_pkg::in_item_t item_i,
  input  wire                  consume_i,
  output logic                 valid_o,
  output wfsp_pkg::in_item_t   item_o
);

  logic               valid_q;
  wfsp_pkg::in_item_t item_q;

  // A held item that leaves this cycle frees the register for a new one.
  assign ready_o = !valid_q || consume_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/wfsp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsp_parser: per-byte frame state and element walk
// Counts bytes, latches the frame header fields and addresses, walks the
// tagged elements and keeps the first SSID. Builds the summary from the
// state as it stands after the current byte.
// ----------------------------------------------------------------------------
module wfsp_parser #(
  parameter int unsigned SSID_MAX_BYTES = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  consume_i,
  input  wire wfsp_pkg::in_item_t item_i,
  output logic                 emit_o,
  output wfsp_pkg::summary_t   summary_o
);

  localparam int unsigned IDX_W = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;

  logic [wfsp_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [7:0]                      fc_q, fc_d;
  logic [47:0]                     src_q, src_d;
  logic [47:0]                     bssid_q, bssid_d;
  logic [wfsp_pkg::COUNT_W-1:0]    next_start_q, next_start_d;
  logic [1:0]                      phase_q, phase_d;
  logic [7:0]                      eid_q, eid_d;
  logic [7:0]                      remain_q, remain_d;
  logic [wfsp_pkg::SSID_CNT_W-1:0] cnt_q, cnt_d;
  logic                            done_q, done_d;
  logic signed [7:0]               rssi_q, rssi_d;
  logic [7:0]                      chan_q, chan_d;
  logic                            misc_q, misc_d;
  logic [7:0]                      ssid_q [SSID_MAX_BYTES];

  logic [wfsp_pkg::COUNT_W-1:0]    pos;
  logic [wfsp_pkg::COUNT_W-1:0]    frame_len;
  logic [wfsp_pkg::COUNT_W:0]      ie_next;
  logic                            wr_en;
  logic [1:0]                      new_type;
  logic [3:0]                      new_sub;

  assign pos      = count_q;
  assign new_type = item_i.data[3:2];
  assign new_sub  = item_i.data[7:4];
  assign ie_next  = {1'b0, pos} + 17'd1 + {9'd0, item_i.data};
  assign frame_len = (pos == wfsp_pkg::COUNT_MAX) ? pos : pos + 16'd1;

  always_comb begin
    fc_d         = fc_q;
    src_d        = src_q;
    bssid_d      = bssid_q;
    next_start_d = next_start_q;
    phase_d      = phase_q;
    eid_d        = eid_q;
    remain_d     = remain_q;
    cnt_d        = cnt_q;
    done_d       = done_q;
    rssi_d       = rssi_q;
    chan_d       = chan_q;
    misc_d       = misc_q;
    wr_en        = 1'b0;

    if (pos == '0) begin
      // First byte: frame control, side fields, fresh walk.
      fc_d     = item_i.data;
      rssi_d   = item_i.rssi;
      chan_d   = item_i.channel;
      misc_d   = item_i.misc;
      src_d    = '0;
      bssid_d  = '0;
      cnt_d    = '0;
      done_d   = 1'b0;
      eid_d    = '0;
      remain_d = '0;
      if (new_type == wfsp_pkg::TYPE_MGMT &&
          (new_sub == wfsp_pkg::SUB_BEACON || new_sub == wfsp_pkg::SUB_PROBE_RESP)) begin
        next_start_d = wfsp_pkg::IE_START_FIXED;
        phase_d      = wfsp_pkg::PH_SEEK;
      end else if (new_type == wfsp_pkg::TYPE_MGMT && new_sub == wfsp_pkg::SUB_PROBE_REQ) begin
        next_start_d = wfsp_pkg::IE_START_PREQ;
        phase_d      = wfsp_pkg::PH_SEEK;
      end else begin
        next_start_d = '0;
        phase_d      = wfsp_pkg::PH_DONE;
      end
    end else if (pos != wfsp_pkg::COUNT_MAX) begin
      for (int i = 0; i < 6; i++) begin
        if (pos == wfsp_pkg::POS_SRC + 16'(i)) begin
          src_d[8*i +: 8] = item_i.data;
        end
        if (pos == wfsp_pkg::POS_BSSID + 16'(i)) begin
          bssid_d[8*i +: 8] = item_i.data;
        end
      end
      case (phase_q)
        wfsp_pkg::PH_SEEK: begin
          if (pos == next_start_q) begin
            eid_d   = item_i.data;
            phase_d = wfsp_pkg::PH_LEN;
          end
        end
        wfsp_pkg::PH_LEN: begin
          if (eid_q == wfsp_pkg::EID_SSID) begin
            remain_d = item_i.data;
            if (item_i.data == 8'd0) begin
              done_d  = 1'b1;
              phase_d = wfsp_pkg::PH_DONE;
            end else begin
              phase_d = wfsp_pkg::PH_DATA;
            end
          end else if (ie_next[wfsp_pkg::COUNT_W]) begin
            phase_d = wfsp_pkg::PH_DONE;
          end else begin
            next_start_d = ie_next[wfsp_pkg::COUNT_W-1:0];
            phase_d      = wfsp_pkg::PH_SEEK;
          end
        end
        wfsp_pkg::PH_DATA: begin
          if (cnt_q < wfsp_pkg::SSID_CNT_W'(SSID_MAX_BYTES)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 6'd1;
          end
          remain_d = remain_q - 8'd1;
          if (remain_q == 8'd1) begin
            done_d  = 1'b1;
            phase_d = wfsp_pkg::PH_DONE;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    if (item_i.last) begin
      count_d = '0;
    end else begin
      count_d = frame_len;
    end
  end

  // A frame reports only when it is long enough and not a misc packet.
  assign emit_o = consume_i && item_i.last && !misc_d &&
                  (frame_len >= wfsp_pkg::MIN_FRAME_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      fc_q         <= '0;
      src_q        <= '0;
      bssid_q      <= '0;
      next_start_q <= '0;
      phase_q      <= wfsp_pkg::PH_SEEK;
      eid_q        <= '0;
      remain_q     <= '0;
      cnt_q        <= '0;
      done_q       <= 1'b0;
      rssi_q       <= '0;
      chan_q       <= '0;
      misc_q       <= 1'b0;
    end else if (consume_i) begin
      count_q      <= count_d;
      fc_q         <= fc_d;
      src_q        <= src_d;
      bssid_q      <= bssid_d;
      next_start_q <= next_start_d;
      phase_q      <= phase_d;
      eid_q        <= eid_d;
      remain_q     <= remain_d;
      cnt_q        <= cnt_d;
      done_q       <= done_d;
      rssi_q       <= rssi_d;
      chan_q       <= chan_d;
      misc_q       <= misc_d;
    end
  end

  // SSID bytes; slots at or past the count are masked on the way out.
  always_ff @(posedge clk_i) begin
    if (consume_i && wr_en) begin
      ssid_q[cnt_q[IDX_W-1:0]] <= item_i.data;
    end
  end

  logic [wfsp_pkg::SSID_SLOTS-1:0][7:0] ssid_bytes;

  for (genvar k = 0; k < wfsp_pkg::SSID_SLOTS; k++) begin : g_slot
    if (k < SSID_MAX_BYTES) begin : g_live
      logic [7:0] slot_view;
      assign slot_view = (wr_en && cnt_q == wfsp_pkg::SSID_CNT_W'(k)) ? item_i.data
                                                                      : ssid_q[k];
      assign ssid_bytes[k] = (done_d && cnt_d > wfsp_pkg::SSID_CNT_W'(k)) ? slot_view
                                                                          : 8'd0;
    end else begin : g_none
      assign ssid_bytes[k] = 8'd0;
    end
  end

  always_comb begin
    summary_o.ftype      = fc_d[3:2];
    summary_o.subtype    = fc_d[7:4];
    summary_o.rssi       = rssi_d;
    summary_o.channel    = chan_d;
    summary_o.source_mac = src_d;
    summary_o.bssid_mac  = bssid_d;
    summary_o.ssid_len   = done_d ? cnt_d : '0;
    summary_o.ssid_word  = ssid_bytes;
  end

  // The SSID count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wfsp_pkg::SSID_CNT_W'(SSID_MAX_BYTES))
    else $error("SSID count beyond store depth");

  // An SSID body in progress always has bytes left.
  a_data_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wfsp_pkg::PH_DATA |-> remain_q != 8'd0)
    else $error("SSID body phase with no bytes left");

  // While seeking, the next element header never lies behind the byte count.
  a_seek_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wfsp_pkg::PH_SEEK && count_q != '0) |-> next_start_q >= count_q)
    else $error("Element start passed without being seen");

  // A consumed last byte always rewinds the byte count.
  a_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume_i && item_i.last) |=> count_q == '0)
    else $error("Byte count not cleared after frame end");

endmodule
`default_nettype wire

// File: sv/wfsp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfsp_out_reg: result register
// Holds one packed summary until the downstream side takes it.
// ----------------------------------------------------------------------------
module wfsp_out_reg (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 load_i,
  input  wire wfsp_pkg::summary_t             summary_i,
  input  wire                                 ready_i,
  output logic                                valid_o,
  output logic [wfsp_pkg::OUT_DATA_W-1:0]     data_o
);

  localparam int unsigned SUM_W = $bits(wfsp_pkg::summary_t);

  logic                                valid_q;
  logic [wfsp_pkg::OUT_DATA_W-1:0]     data_q;
  logic [wfsp_pkg::OUT_DATA_W-1:0]     data_d;

  // Pack the first field into the lowest bits, zero fill to a whole byte.
  always_comb begin
    data_d = '0;
    data_d[SUM_W-1:0] = {summary_i.ssid_word, summary_i.ssid_len, summary_i.bssid_mac,
                         summary_i.source_mac, summary_i.channel, summary_i.rssi,
                         summary_i.subtype, summary_i.ftype};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// File: sv/wlan_frame_summary_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlan_frame_summary_parser: 802.11 frame summary and SSID extraction
// Takes a captured frame one byte per transfer and gives one summary
// transfer at the end of each qualifying frame.
// ----------------------------------------------------------------------------
// The block accepts one frame byte per clock cycle, back to back, and gives
// one summary transfer for each frame of at least 24 bytes that is not
// flagged as a misc packet. The rssi, channel and misc flag are sampled with
// the first byte of a frame, which is the first transfer after reset or after
// a transfer with tlast set. Each byte passes through an input register and
// combinational parsing logic. A summary is loaded into the result register
// when the last byte of its frame leaves the input register, and the result
// register presents it on the master side. Bytes keep flowing while an
// earlier summary waits in the result register. Only a last byte can be held
// back, and only while a previous summary has not yet been taken. The summary
// carries type, subtype, rssi, channel, addr2 and addr3, plus the first SSID
// element of beacon, probe response and probe request frames, cut to
// SSID_MAX_BYTES bytes; an element that runs past the end of the frame ends
// the element walk and leaves the SSID length at zero. Frames longer than
// 65535 bytes are parsed only over their first 65535 bytes.
// ----------------------------------------------------------------------------
module wlan_frame_summary_parser #(
  parameter int unsigned SSID_MAX_BYTES = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input stream.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: data_byte[7:0], frame_rssi[15:8], frame_channel[23:16].
  input  wire  [wfsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tlast: last_byte.
  input  wire                                s_axis_tlast,
  // tuser: misc_packet.
  input  wire                                s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata: frame_type[1:0], frame_subtype[5:2], signal_dbm[13:6],
  // radio_channel[21:14], source_mac[69:22], bssid_mac[117:70],
  // ssid_len[123:118], ssid_word0[187:124], ssid_word1[251:188],
  // ssid_word2[315:252], ssid_word3[379:316], zero fill above.
  output logic [wfsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  wfsp_pkg::in_item_t  in_item;
  wfsp_pkg::in_item_t  held_item;
  wfsp_pkg::summary_t  summary;
  logic                held_valid;
  logic                consume;
  logic                emit;

  always_comb begin
    in_item.data    = s_axis_tdata[7:0];
    in_item.last    = s_axis_tlast;
    in_item.rssi    = s_axis_tdata[15:8];
    in_item.channel = s_axis_tdata[23:16];
    in_item.misc    = s_axis_tuser;
  end

  // A byte that cannot end a frame never waits; a last byte waits only for
  // room in the result register.
  assign consume = held_valid && (!held_item.last || !m_axis_tvalid || m_axis_tready);

  wfsp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .consume_i (consume),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  wfsp_parser #(
    .SSID_MAX_BYTES (SSID_MAX_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (consume),
    .item_i    (held_item),
    .emit_o    (emit),
    .summary_o (summary)
  );

  wfsp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit),
    .summary_i (summary),
    .ready_i   (m_axis_tready),
    .valid_o   (m_axis_tvalid),
    .data_o    (m_axis_tdata)
  );

  // A summary is loaded only when the result register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("Summary overwrote an untaken result");

  // A summary is only ever produced by a consumed last byte.
  a_emit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (consume && held_item.last))
    else $error("Summary without a frame end");

  // A loaded summary is presented in the next cycle.
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid)
    else $error("Loaded summary not presented");

endmodule
`default_nettype wire

// File: tb/wlan_frame_summary_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlan_frame_summary_parser_tb: self-checking bench for the frame summary parser
// Streams directed and random 802.11 frames into the parser one byte per
// transfer. A behavioral copy of the parser predicts each summary, and every
// summary transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wlan_frame_summary_parser_tb;

  localparam int unsigned SSID_KEEP     = 32;
  localparam logic [7:0]  EID_VENDOR    = 8'hDD;
  localparam logic [1:0]  TYPE_CTRL     = 2'd1;
  localparam logic [1:0]  TYPE_DATA     = 2'd2;
  localparam logic [3:0]  SUB_ASSOC_REQ = 4'd0;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic [wfsp_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            s_axis_tlast  = 1'b0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            m_axis_tready = 1'b0;
  wire                             s_axis_tready;
  wire                             m_axis_tvalid;
  wire [wfsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

  wlan_frame_summary_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Traffic shaping knobs, changed by the test tasks.
  int send_idle_pct   = 0;
  int ready_stall_pct = 0;
  int hold_cycles     = 0;

  int errors     = 0;
  int bytes_sent = 0;

  wfsp_pkg::summary_t expected_summaries[$];
  logic [7:0]         frame_buf[$];

  // Behavioral copy of the parser state.
  logic [wfsp_pkg::COUNT_W-1:0]    byte_cnt   = '0;
  logic [7:0]                      fc_byte    = '0;
  logic [47:0]                     src_acc    = '0;
  logic [47:0]                     bssid_acc  = '0;
  logic [wfsp_pkg::COUNT_W-1:0]    ie_next    = '0;
  logic [1:0]                      ie_phase   = wfsp_pkg::PH_SEEK;
  logic [7:0]                      ie_id      = '0;
  logic [7:0]                      ie_left    = '0;
  logic [7:0]                      ssid_bytes [SSID_KEEP];
  logic [wfsp_pkg::SSID_CNT_W-1:0] ssid_cnt   = '0;
  logic                            ssid_found = 1'b0;
  logic [7:0]                      lat_rssi   = '0;
  logic [7:0]                      lat_chan   = '0;
  logic                            lat_misc   = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Advances the parser copy by one accepted byte and queues the summary that
  // a closing byte of a qualifying frame produces.
  task automatic parse_byte(input logic [7:0] b, input logic last, input logic [7:0] rssi,
                            input logic [7:0] chan, input logic misc);
    logic [wfsp_pkg::COUNT_W-1:0] pos;
    logic [wfsp_pkg::COUNT_W-1:0] flen;
    logic [16:0]                  nxt;
    wfsp_pkg::summary_t           s;
    pos = byte_cnt;
    if (pos == '0) begin
      fc_byte    = b;
      lat_rssi   = rssi;
      lat_chan   = chan;
      lat_misc   = misc;
      src_acc    = '0;
      bssid_acc  = '0;
      ssid_bytes = '{default: 8'h00};
      ssid_cnt   = '0;
      ssid_found = 1'b0;
      ie_id      = '0;
      ie_left    = '0;
      if (b[3:2] == wfsp_pkg::TYPE_MGMT &&
          (b[7:4] == wfsp_pkg::SUB_BEACON || b[7:4] == wfsp_pkg::SUB_PROBE_RESP)) begin
        ie_next  = wfsp_pkg::IE_START_FIXED;
        ie_phase = wfsp_pkg::PH_SEEK;
      end else if (b[3:2] == wfsp_pkg::TYPE_MGMT && b[7:4] == wfsp_pkg::SUB_PROBE_REQ) begin
        ie_next  = wfsp_pkg::IE_START_PREQ;
        ie_phase = wfsp_pkg::PH_SEEK;
      end else begin
        ie_next  = '0;
        ie_phase = wfsp_pkg::PH_DONE;
      end
    end
    // Once the counter sits at its ceiling, bytes only matter for their tlast.
    if (pos != wfsp_pkg::COUNT_MAX) begin
      if (pos >= wfsp_pkg::POS_SRC && pos < wfsp_pkg::POS_SRC + 16'd6) begin
        src_acc[8*(pos-wfsp_pkg::POS_SRC) +: 8] = b;
      end else if (pos >= wfsp_pkg::POS_BSSID && pos < wfsp_pkg::POS_BSSID + 16'd6) begin
        bssid_acc[8*(pos-wfsp_pkg::POS_BSSID) +: 8] = b;
      end
      case (ie_phase)
        wfsp_pkg::PH_SEEK: begin
          if (pos == ie_next) begin
            ie_id    = b;
            ie_phase = wfsp_pkg::PH_LEN;
          end
        end
        wfsp_pkg::PH_LEN: begin
          if (ie_id == wfsp_pkg::EID_SSID) begin
            ie_left = b;
            if (b == 8'd0) begin
              ssid_found = 1'b1;
              ie_phase   = wfsp_pkg::PH_DONE;
            end else begin
              ie_phase = wfsp_pkg::PH_DATA;
            end
          end else begin
            // Skip the element body; a start beyond the counter ends the walk.
            nxt = {1'b0, pos} + 17'd1 + {9'd0, b};
            if (nxt > {1'b0, wfsp_pkg::COUNT_MAX}) begin
              ie_phase = wfsp_pkg::PH_DONE;
            end else begin
              ie_next  = nxt[wfsp_pkg::COUNT_W-1:0];
              ie_phase = wfsp_pkg::PH_SEEK;
            end
          end
        end
        wfsp_pkg::PH_DATA: begin
          if (ssid_cnt < SSID_KEEP) begin
            ssid_bytes[ssid_cnt] = b;
            ssid_cnt++;
          end
          ie_left--;
          if (ie_left == 8'd0) begin
            ssid_found = 1'b1;
            ie_phase   = wfsp_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
      byte_cnt = pos + 16'd1;
    end
    if (last) begin
      flen     = byte_cnt;
      byte_cnt = '0;
      if (!lat_misc && flen >= wfsp_pkg::MIN_FRAME_LEN) begin
        s            = '0;
        s.ftype      = fc_byte[3:2];
        s.subtype    = fc_byte[7:4];
        s.rssi       = lat_rssi;
        s.channel    = lat_chan;
        s.source_mac = src_acc;
        s.bssid_mac  = bssid_acc;
        // A partly received SSID is dropped as a whole.
        if (ssid_found) begin
          s.ssid_len = ssid_cnt;
          for (int w = 0; w < wfsp_pkg::SSID_WORDS; w++) begin
            for (int k = 0; k < 8; k++) begin
              s.ssid_word[w][8*k +: 8] = ssid_bytes[8*w+k];
            end
          end
        end
        expected_summaries.push_back(s);
      end
    end
  endtask

  // Offers one byte on the slave side and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] rssi,
                           input logic [7:0] chan, input logic misc);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= wfsp_pkg::IN_DATA_W'($urandom);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {chan, rssi, b};
    s_axis_tlast  <= last;
    s_axis_tuser  <= misc;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    parse_byte(b, last, rssi, chan, misc);
  endtask

  // Sends frame_buf as one frame. Side fields of later bytes are noise, since
  // the parser only samples them with the first byte.
  task automatic send_frame(input logic [7:0] rssi, input logic [7:0] chan, input logic misc);
    for (int i = 0; i < frame_buf.size(); i++) begin
      if (i == 0) begin
        send_byte(frame_buf[i], frame_buf.size() == 1, rssi, chan, misc);
      end else begin
        send_byte(frame_buf[i], i == frame_buf.size() - 1, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic start_header(input logic [1:0] ftype, input logic [3:0] sub);
    frame_buf.delete();
    frame_buf.push_back({sub, ftype, 2'($urandom_range(3))});
    repeat (23) frame_buf.push_back(8'($urandom_range(255)));
    // Beacon and probe response carry twelve bytes of fixed fields.
    if (ftype == wfsp_pkg::TYPE_MGMT &&
        (sub == wfsp_pkg::SUB_BEACON || sub == wfsp_pkg::SUB_PROBE_RESP)) begin
      repeat (12) frame_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic add_element(input logic [7:0] id, input int len);
    frame_buf.push_back(id);
    frame_buf.push_back(8'(len));
    repeat (len) frame_buf.push_back(8'($urandom_range(255)));
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_summary(input logic [wfsp_pkg::OUT_DATA_W-1:0] got);
    wfsp_pkg::summary_t want;
    if (expected_summaries.size() == 0) begin
      errors++;
      $display("%0t: summary with none expected, expected nothing, actual %h", $time, got);
    end else begin
      want = expected_summaries.pop_front();
      cmp_field("frame_type", want.ftype, got[1:0]);
      cmp_field("frame_subtype", want.subtype, got[5:2]);
      cmp_field("signal_dbm", $unsigned(want.rssi), got[13:6]);
      cmp_field("radio_channel", want.channel, got[21:14]);
      cmp_field("source_mac", want.source_mac, got[69:22]);
      cmp_field("bssid_mac", want.bssid_mac, got[117:70]);
      cmp_field("ssid_len", want.ssid_len, got[123:118]);
      for (int w = 0; w < wfsp_pkg::SSID_WORDS; w++) begin
        cmp_field($sformatf("ssid_word%0d", w), want.ssid_word[w], got[124+64*w +: 64]);
      end
      cmp_field("zero fill", '0, got[wfsp_pkg::OUT_DATA_W-1:380]);
    end
  endtask

  // Every summary transfer is checked at the edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_summary(m_axis_tdata);
    end
  end

  // Receiver: a requested hold-off overrides the random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Header extremes, frame-length limits, misc packets and frame kinds that
  // are never walked.
  task automatic test_header_fields();
    frame_buf.delete();
    repeat (24) frame_buf.push_back(8'hFF);
    send_frame(8'h7F, 8'hFF, 1'b0);
    frame_buf.delete();
    repeat (24) frame_buf.push_back(8'h00);
    send_frame(8'h80, 8'h00, 1'b0);
    start_header(TYPE_DATA, 4'($urandom_range(15)));
    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    // One byte short of the minimum length.
    start_header(wfsp_pkg::TYPE_MGMT, SUB_ASSOC_REQ);
    void'(frame_buf.pop_back());
    send_frame(8'h12, 8'h06, 1'b0);
    frame_buf.delete();
    frame_buf.push_back({wfsp_pkg::SUB_BEACON, wfsp_pkg::TYPE_MGMT, 2'b00});
    send_frame(8'hC4, 8'h0B, 1'b0);
    // A valid beacon flagged as a misc packet.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_BEACON);
    add_element(wfsp_pkg::EID_SSID, 6);
    send_frame(8'hD0, 8'h01, 1'b1);
    // Beacon subtype under the control type is not walked.
    start_header(TYPE_CTRL, wfsp_pkg::SUB_BEACON);
    repeat (12) frame_buf.push_back(8'($urandom_range(255)));
    add_element(wfsp_pkg::EID_SSID, 6);
    send_frame(8'hB5, 8'h24, 1'b0);
    start_header(wfsp_pkg::TYPE_MGMT, SUB_ASSOC_REQ);
    add_element(wfsp_pkg::EID_SSID, 6);
    send_frame(8'hA0, 8'h95, 1'b0);
  endtask

  // SSID element placement, size and truncation cases.
  task automatic test_ssid_elements();
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_BEACON);
    add_element(wfsp_pkg::EID_SSID, 5);
    send_frame(8'hC8, 8'h01, 1'b0);
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_PROBE_RESP);
    add_element(EID_VENDOR, 9);
    add_element(wfsp_pkg::EID_SSID, 32);
    add_element(8'h01, 4);
    send_frame(8'hBE, 8'h06, 1'b0);
    // Longer than the store: only the first 32 bytes are kept.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_PROBE_REQ);
    add_element(wfsp_pkg::EID_SSID, 40);
    send_frame(8'hE2, 8'h0B, 1'b0);
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_PROBE_REQ);
    add_element(wfsp_pkg::EID_SSID, 255);
    send_frame(8'h00, 8'h0D, 1'b0);
    // Empty SSID element.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_BEACON);
    add_element(wfsp_pkg::EID_SSID, 0);
    add_element(EID_VENDOR, 3);
    send_frame(8'hD8, 8'h24, 1'b0);
    // Frame ends inside the SSID body.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_BEACON);
    add_element(wfsp_pkg::EID_SSID, 10);
    repeat (5) void'(frame_buf.pop_back());
    send_frame(8'hCA, 8'h30, 1'b0);
    // Frame ends on the SSID length byte, then on an element id byte.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_PROBE_RESP);
    frame_buf.push_back(wfsp_pkg::EID_SSID);
    frame_buf.push_back(8'd4);
    send_frame(8'hCB, 8'h31, 1'b0);
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_PROBE_REQ);
    frame_buf.push_back(wfsp_pkg::EID_SSID);
    send_frame(8'hCC, 8'h32, 1'b0);
    // A skipped element that runs past the end of the frame.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_PROBE_REQ);
    add_element(EID_VENDOR, 50);
    repeat (40) void'(frame_buf.pop_back());
    send_frame(8'hCD, 8'h33, 1'b0);
    // Only the first of two SSID elements counts.
    start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_BEACON);
    add_element(wfsp_pkg::EID_SSID, 7);
    add_element(wfsp_pkg::EID_SSID, 12);
    send_frame(8'hCE, 8'h34, 1'b0);
  endtask

  // The receiver holds off long enough for a second summary to back up and
  // stall the input on its last byte.
  task automatic test_backpressure();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    @(posedge clk_i);
    hold_cycles = 300;
    repeat (6) begin
      start_header(wfsp_pkg::TYPE_MGMT, wfsp_pkg::SUB_BEACON);
      add_element(wfsp_pkg::EID_SSID, $urandom_range(0, 32));
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic random_frame();
    int          kind;
    int          n;
    logic [3:0]  sub;
    logic [7:0]  rssi;
    logic [7:0]  chan;
    logic        misc;
    kind = $urandom_range(99);
    rssi = 8'($urandom_range(255));
    chan = 8'($urandom_range(255));
    misc = ($urandom_range(99) < 6);
    case ($urandom_range(2))
      0:       sub = wfsp_pkg::SUB_BEACON;
      1:       sub = wfsp_pkg::SUB_PROBE_RESP;
      default: sub = wfsp_pkg::SUB_PROBE_REQ;
    endcase
    if (kind < 60) begin
      // Well-formed element list with random content, sometimes cut short.
      start_header(wfsp_pkg::TYPE_MGMT, sub);
      repeat ($urandom_range(2)) add_element(8'($urandom_range(1, 255)), $urandom_range(0, 20));
      if ($urandom_range(99) < 15) begin
        add_element(wfsp_pkg::EID_SSID, $urandom_range(33, 255));
      end else begin
        add_element(wfsp_pkg::EID_SSID, $urandom_range(0, 32));
      end
      if ($urandom_range(1) == 1) begin
        add_element(8'($urandom_range(1, 255)), $urandom_range(0, 10));
      end
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(1, frame_buf.size() - 1);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end
    end else if (kind < 80) begin
      start_header(2'($urandom_range(3)), 4'($urandom_range(15)));
      repeat ($urandom_range(0, 40)) frame_buf.push_back(8'($urandom_range(255)));
    end else if (kind < 90) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 23)) frame_buf.push_back(8'($urandom_range(255)));
    end else begin
      // Walked frame kinds with noise where the elements should be.
      start_header(wfsp_pkg::TYPE_MGMT, sub);
      repeat ($urandom_range(0, 60)) frame_buf.push_back(8'($urandom_range(255)));
    end
    send_frame(rssi, chan, misc);
  endtask

  task automatic test_random_traffic();
    int idle_tbl[4]  = '{0, 79, 0, 33};
    int stall_tbl[4] = '{0, 0, 79, 33};
    int bytes_mark;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct   = idle_tbl[ph];
      ready_stall_pct = stall_tbl[ph];
      bytes_mark      = bytes_sent;
      while (bytes_sent - bytes_mark < 160) begin
        random_frame();
      end
    end
  endtask

  initial begin
    int drain_cycles;
    drain_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct   = 33;
    ready_stall_pct = 33;
    test_header_fields();
    test_ssid_elements();
    test_backpressure();
    test_random_traffic();

    @(negedge clk_i);
    s_axis_tvalid   <= 1'b0;
    ready_stall_pct = 0;
    while (expected_summaries.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    // A last byte passes the input register and then the result register before its summary shows.
    repeat (20) @(posedge clk_i);
    if (expected_summaries.size() != 0) begin
      errors++;
      $display("%0t: summaries never arrived, expected %0d more, actual 0", $time,
               expected_summaries.size());
    end
    if (errors == 0) begin
      $display("[wlan_frame_summary_parser] OK");
    end else begin
      $display("[wlan_frame_summary_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("[wlan_frame_summary_parser] ERROR");
    $finish;
  end

endmodule

// File: wlan_frame_summary_parser.f
sv/wfsp_pkg.sv
sv/wfsp_in_reg.sv
sv/wfsp_parser.sv
sv/wfsp_out_reg.sv
sv/wlan_frame_summary_parser.sv
tb/wlan_frame_summary_parser_tb.sv
